[rtl/core/scf_pkg.sv]
// scf_pkg: shared types, widths and register codes of the sphere frustum culler
// no dependencies; used by every module under rtl/core
`default_nettype none

package scf_pkg;

   // sizing
   localparam int MAX_INSTANCES = 65536;
   localparam int MAX_PLANES    = 6;
   localparam int CNT_W         = $clog2(MAX_INSTANCES) + 1;

   // fixed field widths
   localparam int COORD_W      = 16;
   localparam int INDEX_W      = 16;
   localparam int FRAME_CNT_W  = 17;
   localparam int TOTAL_W      = 32;
   localparam int R2_W         = 32;
   localparam int PROD_W       = 32;
   localparam int DIST_W       = 34;
   localparam int MAG_W        = 32;
   localparam int SQ_W         = 64;
   localparam int OFFSET_SHIFT = 14;
   localparam int R2_SHIFT     = 28;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_ZERO    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANES_IN_USE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CULL_EN       = 3'd7;
   localparam logic [2:0]           PLANES_IN_USE_RST = 3'd6;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // result kinds
   localparam logic KIND_INDEX   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // input transaction
   typedef struct packed {
      logic                      frame_end;
      logic signed [COORD_W-1:0] scale_z;
      logic signed [COORD_W-1:0] scale_y;
      logic signed [COORD_W-1:0] scale_x;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_x;
   } req_type;

   // result transaction
   typedef struct packed {
      logic                   kind;
      logic [INDEX_W-1:0]     instance_index;
      logic [FRAME_CNT_W-1:0] frame_culled;
      logic [FRAME_CNT_W-1:0] frame_visible;
      logic [TOTAL_W-1:0]     culled_total;
      logic                   last;
   } rsp_type;

   // one plane register: offset on top, normal below
   typedef struct packed {
      logic signed [COORD_W-1:0] w;
      logic signed [COORD_W-1:0] nz;
      logic signed [COORD_W-1:0] ny;
      logic signed [COORD_W-1:0] nx;
   } plane_type;

   // instance as it travels down the cell chain
   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [R2_W-1:0]           r2;
      logic                      frame_end;
      logic                      culled;
   } item_type;

endpackage

`default_nettype wire

[rtl/core/sphere_frustum_culler_top.sv]
// sphere_frustum_culler_top: bounding sphere frustum culler, radius stage,
// chain of plane cells and tally; depends on scf_pkg, scf_radius, scf_cell, scf_tally
//
// Usage:
//   req_*  instance transactions (position, scale, frame_end), valid/ready.
//   rsp_*  result transactions: a visible instance's index, and a frame summary
//          after the last instance of a frame, valid/ready.
//   csr_*  register writes: index 0..5 planes, 6 planes in use, 7 culling enable;
//          csr_ready is always high, write only while the block is idle.
// Pipeline: a transaction passes 2 radius stages, 4 stages in each of the 6 plane
//   cells and 1 queue write, the first of them loaded at the accepting edge.
// Throughput: one instance per cycle while the chain is not stalled; the chain holds
//   one instance per stage. A frame end on a visible instance makes two results,
//   so the rsp port at one result per cycle is then the limit.
// Reset: counters and running total clear, planes read as zero, all planes in
//   use and culling enabled; no clearing pass, the block accepts at once.
// Stall: a 4-entry result queue sits at the output; when fewer than two entries
//   are free the whole chain holds and req_ready drops.
`default_nettype none

module sphere_frustum_culler_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire scf_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output scf_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [scf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [scf_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic       adv;
   logic [2:0] planes_in_use_ff;
   logic       cull_en_ff;
   logic [scf_pkg::MAX_PLANES-1:0] plane_we;
   logic [scf_pkg::MAX_PLANES-1:0] plane_on;
   scf_pkg::item_type chain [scf_pkg::MAX_PLANES+1];

   assign csr_ready = 1'b1;
   assign req_ready = adv;

   // global registers
   always_ff @(posedge clock) begin
      if (reset) begin
         planes_in_use_ff <= scf_pkg::PLANES_IN_USE_RST;
         cull_en_ff       <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == scf_pkg::REG_PLANES_IN_USE) begin
            planes_in_use_ff <= csr_data[2:0];
         end
         if (csr_index == scf_pkg::REG_CULL_EN) begin
            cull_en_ff <= csr_data[0];
         end
      end
   end

   // plane write decode and enables
   always_comb begin
      for (int i = 0; i < scf_pkg::MAX_PLANES; i++) begin
         plane_we[i] = csr_valid
                     & (csr_index == (scf_pkg::REG_PLANE_ZERO + scf_pkg::CSR_IDX_W'(i)));
         plane_on[i] = cull_en_ff & (3'(i) < planes_in_use_ff);
      end
   end

   scf_radius u_radius (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .req_take (req_valid),
      .req      (req_data),
      .item_o   (chain[0])
   );

   // one cell per plane
   for (genvar g = 0; g < scf_pkg::MAX_PLANES; g++) begin : g_cell
      scf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .plane_we   (plane_we[g]),
         .plane_data (scf_pkg::plane_type'(csr_data)),
         .plane_on   (plane_on[g]),
         .item_i     (chain[g]),
         .item_o     (chain[g+1])
      );
   end

   scf_tally u_tally (
      .clock     (clock),
      .reset     (reset),
      .item_i    (chain[scf_pkg::MAX_PLANES]),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/scf_radius.sv]
// scf_radius: two-stage squared radius of the scale vector, entry of the cell chain
// depends on scf_pkg
`default_nettype none

module scf_radius (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             req_take,
   input  wire scf_pkg::req_type req,
   output scf_pkg::item_type     item_o
);

   scf_pkg::req_type            s1_req_ff;
   logic                        s1_valid_ff;
   logic signed [scf_pkg::PROD_W-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [scf_pkg::PROD_W-1:0] sq_x_in, sq_y_in, sq_z_in;
   scf_pkg::item_type           s2_item_ff, s2_item_in;

   // squares of the scale components
   always_comb begin
      sq_x_in = req.scale_x * req.scale_x;
      sq_y_in = req.scale_y * req.scale_y;
      sq_z_in = req.scale_z * req.scale_z;
   end

   // sum of squares and item build
   always_comb begin
      s2_item_in.valid     = s1_valid_ff;
      s2_item_in.pos_x     = s1_req_ff.pos_x;
      s2_item_in.pos_y     = s1_req_ff.pos_y;
      s2_item_in.pos_z     = s1_req_ff.pos_z;
      s2_item_in.r2        = scf_pkg::R2_W'($unsigned(sq_x_ff))
                           + scf_pkg::R2_W'($unsigned(sq_y_ff))
                           + scf_pkg::R2_W'($unsigned(sq_z_ff));
      s2_item_in.frame_end = s1_req_ff.frame_end;
      s2_item_in.culled    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s2_item_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_take;
         s1_req_ff   <= req;
         sq_x_ff     <= sq_x_in;
         sq_y_ff     <= sq_y_in;
         sq_z_ff     <= sq_z_in;
         s2_item_ff  <= s2_item_in;
      end
   end

   assign item_o = s2_item_ff;

endmodule

`default_nettype wire

[rtl/core/scf_cell.sv]
// scf_cell: one plane of the culling chain, holds its plane register and tests
// the passing instance in four stages; depends on scf_pkg
`default_nettype none

module scf_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               plane_we,
   input  wire scf_pkg::plane_type plane_data,
   input  wire logic               plane_on,
   input  wire scf_pkg::item_type  item_i,
   output scf_pkg::item_type       item_o
);

   scf_pkg::plane_type plane_ff;

   scf_pkg::item_type  s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff, s4_item_in;
   logic signed [scf_pkg::PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [scf_pkg::PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [scf_pkg::DIST_W-1:0] dist_in;
   logic [scf_pkg::MAG_W-1:0]         mag_ff, mag_in;
   logic [scf_pkg::SQ_W-1:0]          sq_ff, sq_in;
   logic [scf_pkg::SQ_W-1:0]          r2_scaled;

   // plane register
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (plane_we) begin
         plane_ff <= plane_data;
      end
   end

   // stage 1: normal times position
   always_comb begin
      prod_x_in = plane_ff.nx * item_i.pos_x;
      prod_y_in = plane_ff.ny * item_i.pos_y;
      prod_z_in = plane_ff.nz * item_i.pos_z;
   end

   // stage 2: signed distance, keep magnitude only when behind the plane
   always_comb begin
      dist_in = scf_pkg::DIST_W'(prod_x_ff) + scf_pkg::DIST_W'(prod_y_ff)
              + scf_pkg::DIST_W'(prod_z_ff)
              + (scf_pkg::DIST_W'(plane_ff.w) <<< scf_pkg::OFFSET_SHIFT);
      if (dist_in[scf_pkg::DIST_W-1]) begin
         mag_in = scf_pkg::MAG_W'(-dist_in);
      end else begin
         mag_in = '0;
      end
   end

   // stage 3: distance squared
   assign sq_in = mag_ff * mag_ff;

   // stage 4: compare against radius squared at matching scale
   always_comb begin
      r2_scaled         = scf_pkg::SQ_W'(s3_item_ff.r2) << scf_pkg::R2_SHIFT;
      s4_item_in        = s3_item_ff;
      s4_item_in.culled = s3_item_ff.culled | (plane_on & (sq_ff > r2_scaled));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff.valid <= 1'b0;
         s2_item_ff.valid <= 1'b0;
         s3_item_ff.valid <= 1'b0;
         s4_item_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_item_ff <= item_i;
         prod_x_ff  <= prod_x_in;
         prod_y_ff  <= prod_y_in;
         prod_z_ff  <= prod_z_in;
         s2_item_ff <= s1_item_ff;
         mag_ff     <= mag_in;
         s3_item_ff <= s2_item_ff;
         sq_ff      <= sq_in;
         s4_item_ff <= s4_item_in;
      end
   end

   assign item_o = s4_item_ff;

endmodule

`default_nettype wire

[rtl/core/scf_tally.sv]
// scf_tally: frame counters, running culled total and the result queue
// depends on scf_pkg
`default_nettype none

module scf_tally (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire scf_pkg::item_type item_i,
   output logic                   adv,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output scf_pkg::rsp_type       rsp_data
);

   logic [scf_pkg::CNT_W-1:0]      next_index_ff, next_index_in;
   logic [scf_pkg::CNT_W-1:0]      culled_ff, culled_in, culled_new;
   logic [scf_pkg::CNT_W-1:0]      visible_ff, visible_in, visible_new;
   logic [scf_pkg::TOTAL_W-1:0]    total_ff, total_in;

   scf_pkg::rsp_type               fifo_mem [scf_pkg::FIFO_DEPTH];
   logic [scf_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [scf_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [scf_pkg::FIFO_CNT_W-1:0] count_ff, count_in;

   logic take, counted, is_cull, is_vis, is_sum, pop, push_a, push_b;
   scf_pkg::rsp_type idx_rsp, sum_rsp, first_rsp;

   // room for two results gates the whole chain
   assign adv = count_ff <= scf_pkg::FIFO_CNT_W'(scf_pkg::FIFO_DEPTH - 2);

   // counter update for the transaction leaving the chain
   always_comb begin
      take        = adv & item_i.valid;
      counted     = next_index_ff < scf_pkg::CNT_W'(scf_pkg::MAX_INSTANCES);
      is_cull     = take & counted & item_i.culled;
      is_vis      = take & counted & ~item_i.culled;
      is_sum      = take & item_i.frame_end;
      culled_new  = culled_ff + scf_pkg::CNT_W'(is_cull);
      visible_new = visible_ff + scf_pkg::CNT_W'(is_vis);
      if (is_cull && (total_ff != '1)) begin
         total_in = total_ff + scf_pkg::TOTAL_W'(1);
      end else begin
         total_in = total_ff;
      end
      if (is_sum) begin
         next_index_in = '0;
         culled_in     = '0;
         visible_in    = '0;
      end else begin
         next_index_in = next_index_ff + scf_pkg::CNT_W'(is_cull | is_vis);
         culled_in     = culled_new;
         visible_in    = visible_new;
      end
   end

   // result build
   always_comb begin
      idx_rsp.kind           = scf_pkg::KIND_INDEX;
      idx_rsp.instance_index = scf_pkg::INDEX_W'(next_index_ff);
      idx_rsp.frame_culled   = '0;
      idx_rsp.frame_visible  = '0;
      idx_rsp.culled_total   = '0;
      idx_rsp.last           = ~item_i.frame_end;

      sum_rsp.kind           = scf_pkg::KIND_SUMMARY;
      sum_rsp.instance_index = '0;
      sum_rsp.frame_culled   = scf_pkg::FRAME_CNT_W'(culled_new);
      sum_rsp.frame_visible  = scf_pkg::FRAME_CNT_W'(visible_new);
      sum_rsp.culled_total   = total_in;
      sum_rsp.last           = 1'b1;

      push_a    = is_vis | is_sum;
      push_b    = is_vis & is_sum;
      first_rsp = is_vis ? idx_rsp : sum_rsp;
   end

   // queue pointers
   always_comb begin
      pop         = rsp_valid & rsp_ready;
      wr_ptr_next = wr_ptr_ff + scf_pkg::FIFO_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + scf_pkg::FIFO_PTR_W'(push_a) + scf_pkg::FIFO_PTR_W'(push_b);
      rd_ptr_in   = rd_ptr_ff + scf_pkg::FIFO_PTR_W'(pop);
      count_in    = count_ff + scf_pkg::FIFO_CNT_W'(push_a) + scf_pkg::FIFO_CNT_W'(push_b)
                  - scf_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff <= '0;
         culled_ff     <= '0;
         visible_ff    <= '0;
         total_ff      <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         next_index_ff <= next_index_in;
         culled_ff     <= culled_in;
         visible_ff    <= visible_in;
         total_ff      <= total_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_a) begin
         fifo_mem[wr_ptr_ff] <= first_rsp;
      end
      if (push_b) begin
         fifo_mem[wr_ptr_next] <= sum_rsp;
      end
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = fifo_mem[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   // queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= scf_pkg::FIFO_CNT_W'(scf_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   // every counted instance is either culled or visible
   a_count_split: assert property (@(posedge clock) disable iff (reset)
      (culled_ff + visible_ff) == next_index_ff)
      else $error("frame counts disagree with instance index");

   // index never passes the frame limit
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      next_index_ff <= scf_pkg::CNT_W'(scf_pkg::MAX_INSTANCES))
      else $error("instance index beyond frame limit");

   // a frame end restarts the frame
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      is_sum |=> (next_index_ff == '0) && (culled_ff == '0) && (visible_ff == '0))
      else $error("frame state not cleared after summary");

   // running total never goes down
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> total_ff >= $past(total_ff))
      else $error("culled total decreased");
`endif

endmodule

`default_nettype wire

[tb/tb_sphere_frustum_culler_top.sv]
// tb_sphere_frustum_culler_top: self-checking bench for the sphere frustum culler
// predicts visible indices and frame summaries per instance transaction and
// checks each result in order; depends on scf_pkg and sphere_frustum_culler_top
`timescale 1ns / 1ps

module tb_sphere_frustum_culler_top;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 200;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   scf_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   scf_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [scf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [scf_pkg::CSR_DATA_W-1:0] csr_data;

   // predictor copy of registers and frame state
   scf_pkg::plane_type plane_cfg [scf_pkg::MAX_PLANES];
   logic [2:0] planes_used;
   logic cull_on;
   int unsigned frame_index;
   int unsigned frame_culled_cnt;
   int unsigned frame_visible_cnt;
   logic [scf_pkg::TOTAL_W-1:0] total_culled;

   scf_pkg::rsp_type pending_results [$];

   // run control and bookkeeping
   bit gaps_on;
   bit hold_request;
   int hold_left;
   int fail_count;
   int cycle_count;
   int sent_instances;
   int checked_results;
   int summaries_seen;
   int culled_predicted;
   int csr_writes;

   sphere_frustum_culler_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // sphere against the enabled planes, exact squared comparison
   function automatic bit sphere_outside_frustum(scf_pkg::req_type r);
      longint r2;
      longint plane_dist;
      logic [63:0] mag;
      logic [63:0] r2_scaled;
      int n;
      bit outside;
      r2 = longint'(r.scale_x) * longint'(r.scale_x) +
           longint'(r.scale_y) * longint'(r.scale_y) +
           longint'(r.scale_z) * longint'(r.scale_z);
      r2_scaled = 64'(r2) << scf_pkg::R2_SHIFT;
      n = (planes_used > scf_pkg::MAX_PLANES) ? scf_pkg::MAX_PLANES : int'(planes_used);
      outside = 1'b0;
      for (int p = 0; p < n; p++) begin
         plane_dist = longint'(plane_cfg[p].nx) * longint'(r.pos_x) +
                      longint'(plane_cfg[p].ny) * longint'(r.pos_y) +
                      longint'(plane_cfg[p].nz) * longint'(r.pos_z) +
                      (longint'(plane_cfg[p].w) <<< scf_pkg::OFFSET_SHIFT);
         if (plane_dist < 0) begin
            mag = 64'(-plane_dist);
            if (mag * mag > r2_scaled) outside = 1'b1;
         end
      end
      return outside;
   endfunction

   // expected results of one accepted instance
   task automatic predict_culler(scf_pkg::req_type r);
      scf_pkg::rsp_type res;
      bit culled;
      if (frame_index < scf_pkg::MAX_INSTANCES) begin
         culled = cull_on && sphere_outside_frustum(r);
         if (culled) begin
            frame_culled_cnt++;
            culled_predicted++;
            if (total_culled != '1) total_culled++;
         end else begin
            frame_visible_cnt++;
            res = '0;
            res.kind = scf_pkg::KIND_INDEX;
            res.instance_index = frame_index[scf_pkg::INDEX_W-1:0];
            res.last = !r.frame_end;
            pending_results = {pending_results, res};
         end
         frame_index++;
      end
      if (r.frame_end) begin
         res = '0;
         res.kind = scf_pkg::KIND_SUMMARY;
         res.frame_culled = frame_culled_cnt[scf_pkg::FRAME_CNT_W-1:0];
         res.frame_visible = frame_visible_cnt[scf_pkg::FRAME_CNT_W-1:0];
         res.culled_total = total_culled;
         res.last = 1'b1;
         pending_results = {pending_results, res};
         frame_index = 0;
         frame_culled_cnt = 0;
         frame_visible_cnt = 0;
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      scf_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction, kind %0d", rsp_data.kind);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_data.kind);
            check_field("instance_index", want.instance_index, rsp_data.instance_index);
            check_field("frame_culled", want.frame_culled, rsp_data.frame_culled);
            check_field("frame_visible", want.frame_visible, rsp_data.frame_visible);
            check_field("culled_total", want.culled_total, rsp_data.culled_total);
            check_field("last", want.last, rsp_data.last);
            checked_results++;
            if (want.kind == scf_pkg::KIND_SUMMARY) summaries_seen++;
         end
      end
   end

   // result receiver, random back-pressure and a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !gaps_on || ($urandom_range(99) >= 30);
         end
      end
   end

   // one instance transaction, with random idle cycles ahead of it
   task automatic send_instance(scf_pkg::req_type item);
      while (gaps_on && $urandom_range(99) < 30) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_culler(item);
      sent_instances++;
   endtask

   // stop sending and wait out every result and the pipeline tail
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [scf_pkg::CSR_IDX_W-1:0] idx,
                                 logic [scf_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == scf_pkg::REG_PLANES_IN_USE) planes_used = value[2:0];
      else if (idx == scf_pkg::REG_CULL_EN) cull_on = value[0];
      else plane_cfg[idx - scf_pkg::REG_PLANE_ZERO] = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic scf_pkg::plane_type make_plane(int nx, int ny, int nz, int w);
      scf_pkg::plane_type pl;
      pl.nx = 16'(nx);
      pl.ny = 16'(ny);
      pl.nz = 16'(nz);
      pl.w = 16'(w);
      return pl;
   endfunction

   function automatic scf_pkg::req_type make_instance(int px, int py, int pz,
                                                      int sx, int sy, int sz, bit fe);
      scf_pkg::req_type r;
      r.pos_x = 16'(px);
      r.pos_y = 16'(py);
      r.pos_z = 16'(pz);
      r.scale_x = 16'(sx);
      r.scale_y = 16'(sy);
      r.scale_z = 16'(sz);
      r.frame_end = fe;
      return r;
   endfunction

   // coordinate mixing extremes with either a narrow or a full random range
   function automatic int rand_coord(bit narrow);
      case ($urandom_range(9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         default: begin
            if (narrow) return int'($urandom_range(4095)) - 2048;
            return int'($urandom_range(65535)) - 32768;
         end
      endcase
   endfunction

   // reset values: all planes zero, so nothing is culled
   task automatic test_reset_defaults();
      send_instance(make_instance(32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
      send_instance(make_instance(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
      send_instance(make_instance(0, 0, 0, 0, 0, 0, 1'b0));
      send_instance(make_instance(-1, 1, -1, 1, -1, 1, 1'b1));
      settle_idle();
   endtask

   // tangent sphere, zero distance and extreme coefficients on plane zero
   task automatic test_plane_boundaries();
      write_register(scf_pkg::REG_PLANE_ZERO, make_plane(16384, 0, 0, 0));
      send_instance(make_instance(-256, 0, 0, 256, 0, 0, 1'b0));
      send_instance(make_instance(-256, 0, 0, 255, 0, 0, 1'b0));
      send_instance(make_instance(-256, 0, 0, -256, 0, 0, 1'b0));
      send_instance(make_instance(0, 0, 0, 0, 0, 0, 1'b0));
      send_instance(make_instance(-1, 0, 0, 0, 0, 0, 1'b1));
      settle_idle();
      write_register(scf_pkg::REG_PLANE_ZERO, make_plane(-32768, 32767, -32768, -32768));
      send_instance(make_instance(32767, -32768, 32767, -32768, -32768, -32768, 1'b0));
      send_instance(make_instance(-32768, 32767, -32768, 0, 0, 0, 1'b1));
      settle_idle();
   endtask

   // plane count extremes and the culling switch
   task automatic test_plane_selection();
      write_register(scf_pkg::REG_PLANE_ZERO, make_plane(16384, 0, 0, 0));
      write_register(scf_pkg::REG_PLANE_ZERO + 3'd1, make_plane(-16384, 0, 0, 0));
      write_register(scf_pkg::REG_PLANE_ZERO + 3'd2, make_plane(0, 16384, 0, 0));
      write_register(scf_pkg::REG_PLANE_ZERO + 3'd3, make_plane(0, -16384, 0, 0));
      write_register(scf_pkg::REG_PLANE_ZERO + 3'd4, make_plane(0, 0, 16384, 0));
      write_register(scf_pkg::REG_PLANE_ZERO + 3'd5, make_plane(0, 0, -16384, 0));
      // only the sixth plane would reject this one, and only five planes are in use
      write_register(scf_pkg::REG_PLANES_IN_USE, 64'd5);
      send_instance(make_instance(0, 0, 512, 1, 0, 0, 1'b1));
      settle_idle();
      // count above the plane total is clamped
      write_register(scf_pkg::REG_PLANES_IN_USE, 64'd7);
      send_instance(make_instance(0, 0, 512, 1, 0, 0, 1'b0));
      send_instance(make_instance(-512, 0, 0, 0, 1, 0, 1'b1));
      settle_idle();
      write_register(scf_pkg::REG_PLANES_IN_USE, 64'd0);
      send_instance(make_instance(0, 0, 512, 1, 0, 0, 1'b0));
      send_instance(make_instance(-512, 0, 0, 0, 1, 0, 1'b1));
      settle_idle();
      write_register(scf_pkg::REG_PLANES_IN_USE, 64'd6);
      write_register(scf_pkg::REG_CULL_EN, 64'd0);
      send_instance(make_instance(-512, 0, 0, 0, 1, 0, 1'b0));
      send_instance(make_instance(0, 0, 512, 1, 0, 0, 1'b1));
      settle_idle();
      write_register(scf_pkg::REG_CULL_EN, 64'd1);
   endtask

   // random planes per phase, random instances and frame lengths
   task automatic test_random_traffic();
      scf_pkg::plane_type pl;
      bit narrow;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle_idle();
         for (int p = 0; p < scf_pkg::MAX_PLANES; p++) begin
            case ($urandom_range(2))
               0: pl = scf_pkg::plane_type'({$urandom, $urandom});
               1: begin
                  pl = make_plane(0, 0, 0, int'($urandom_range(8191)) - 4096);
                  case ($urandom_range(2))
                     0: pl.nx = 16'($urandom_range(1) ? 16384 : -16384);
                     1: pl.ny = 16'($urandom_range(1) ? 16384 : -16384);
                     default: pl.nz = 16'($urandom_range(1) ? 16384 : -16384);
                  endcase
               end
               default: pl = make_plane(int'($urandom_range(32767)) - 16384,
                                        int'($urandom_range(32767)) - 16384,
                                        int'($urandom_range(32767)) - 16384,
                                        rand_coord(1'b0));
            endcase
            write_register(scf_pkg::REG_PLANE_ZERO + 3'(p), pl);
         end
         write_register(scf_pkg::REG_PLANES_IN_USE, 64'($urandom_range(7)));
         write_register(scf_pkg::REG_CULL_EN, 64'($urandom_range(99) < 85));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver stall early in the second phase
            if (ph == 1 && i == 5) hold_request = 1'b1;
            // stretch without any idling in the third phase
            if (ph == 2) gaps_on = !(i >= 50 && i < 150);
            narrow = $urandom_range(9) < 7;
            send_instance(make_instance(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                                        rand_coord(narrow), rand_coord(narrow),
                                        rand_coord(narrow), $urandom_range(11) == 0));
         end
         gaps_on = 1'b1;
         // sender waits for every result before the next burst
         settle_idle();
      end
   endtask

   // stimulus sequence
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      gaps_on = 1'b1;
      hold_request = 1'b0;
      fail_count = 0;
      cycle_count = 0;
      sent_instances = 0;
      checked_results = 0;
      summaries_seen = 0;
      culled_predicted = 0;
      csr_writes = 0;
      for (int p = 0; p < scf_pkg::MAX_PLANES; p++) plane_cfg[p] = '0;
      planes_used = scf_pkg::PLANES_IN_USE_RST;
      cull_on = 1'b1;
      frame_index = 0;
      frame_culled_cnt = 0;
      frame_visible_cnt = 0;
      total_culled = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_plane_boundaries();
      test_plane_selection();
      test_random_traffic();
      settle_idle();

      $display("tb: %0d instances sent, %0d culled, %0d results checked, %0d frame summaries",
               sent_instances, culled_predicted, checked_results, summaries_seen);
      $display("tb: %0d register writes over reset values, plane edges, plane counts and random planes",
               csr_writes);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/scf_pkg.sv
rtl/core/scf_radius.sv
rtl/core/scf_cell.sv
rtl/core/scf_tally.sv
rtl/core/sphere_frustum_culler_top.sv
tb/tb_sphere_frustum_culler_top.sv
